// ===== design/bhpf_pkg.sv =====
package bhpf_pkg;

   // frame geometry
   localparam int MAX_WIDTH   = 8192;
   localparam int MAX_HEIGHT  = 16384;
   localparam int MIN_WIDTH   = 6;
   localparam int MIN_HEIGHT  = 5;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS  = COL_BITS + 1;
   localparam int HEIGHT_BITS = $clog2(MAX_HEIGHT) + 1;
   localparam int AREA_BITS   = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
   localparam int INDEX_BITS  = AREA_BITS - 1;
   // rows stepped in one frame, drain included, at the narrowest width
   localparam int ROW_BITS    =
      $clog2((2 ** INDEX_BITS + 2 * MAX_WIDTH + 2) / MIN_WIDTH + 1);

   // pixel arithmetic
   localparam int PIXEL_BITS  = 16;
   localparam int GAIN_BITS   = 16;
   localparam int PROD_BITS   = PIXEL_BITS + GAIN_BITS;
   localparam int COUNT_BITS  = 24;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // line store banks, one per buffered row
   localparam int SLOTS       = 4;
   localparam int SLOT_BITS   = $clog2(SLOTS);

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH     = 3'd0,
      CSR_IMAGE_HEIGHT    = 3'd1,
      CSR_HOT_THRESHOLD   = 3'd2,
      CSR_NEIGHBOUR_GAIN  = 3'd3,
      CSR_PERMISSIVE_MODE = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

endpackage

// ===== design/bhpf_req_if.sv =====
interface bhpf_req_if import bhpf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [PIXEL_BITS-1:0] pixel_in;

   modport source (output valid, output opcode, output pixel_in, input ready);
   modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

// ===== design/bhpf_rsp_if.sv =====
interface bhpf_rsp_if import bhpf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_out;
   logic                  corrected;
   logic                  last_of_frame;
   logic [COUNT_BITS-1:0] fixed_count;

   modport source (output valid, output pixel_out, output corrected,
                   output last_of_frame, output fixed_count, input ready);
   modport sink   (input valid, input pixel_out, input corrected,
                   input last_of_frame, input fixed_count, output ready);
endinterface

// ===== design/bhpf_csr_if.sv =====
interface bhpf_csr_if import bhpf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/bhpf_ram.sv =====
module bhpf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read at the written address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bayer_hot_pixel_fix.sv =====
// channel   port     direction  beat contents
// -------   ----     ---------  -------------------------------------------------
// request   req_bus  in         opcode (pixel / flush), pixel_in
// response  rsp_bus  out        pixel_out, corrected, last_of_frame, fixed_count
// control   csr_bus  in         index, data (register write, always ready)
//
// One request beat per cycle while req_bus.ready is high; a response goes through the
// stages after its 5x5 window completes, two rows plus two pixels behind the raster.
// Stages: input register with the line store read, window capture with the
// centre-times-gain multiply, then the compare/select into the response register.
// Reset is synchronous; the line store is not cleared. A width write holds
// req_bus.ready low through the 27-step divide that re-derives the output
// row and column; a height write holds it low for one cycle.
// Each stage holds while full and blocked, so stalls on rsp_bus back up stage by stage.
module bayer_hot_pixel_fix import bhpf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   bhpf_req_if.sink           req_bus,
   bhpf_rsp_if.source         rsp_bus,
   bhpf_csr_if.sink           csr_bus
);

   localparam int WIN      = 5;
   localparam int WIN_MID  = 2;
   localparam int BORDER   = 2;
   localparam int NEED_ALL = 4;
   localparam int NEED_PERMISSIVE = 3;
   localparam int HIT_BITS = 3;
   localparam int DIV_STEPS = INDEX_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

   // configuration registers (geometry held clamped)
   logic [WIDTH_BITS-1:0]  eff_w_ff;
   logic [HEIGHT_BITS-1:0] eff_h_ff;
   logic [PIXEL_BITS-1:0]  thresh_ff;
   logic [GAIN_BITS-1:0]   gain_ff;
   logic                   perm_ff;
   logic [AREA_BITS-1:0]   area_ff;
   logic [WIDTH_BITS+HEIGHT_BITS-1:0] area_wide;
   logic                   settle_ff;

   // position counters
   logic [ROW_BITS-1:0]    in_row_ff, in_row_in;
   logic [COL_BITS-1:0]    in_col_ff, in_col_in;
   logic [INDEX_BITS-1:0]  out_index_ff, out_index_in;
   logic [ROW_BITS-1:0]    orow_ff, orow_in;
   logic [COL_BITS-1:0]    ocol_ff, ocol_in;

   // divider for out_index / width
   logic [DIV_CNT_BITS-1:0] div_cnt_ff;
   logic [INDEX_BITS-1:0]   quot_ff, quot_in;
   logic [COL_BITS-1:0]     rem_ff, rem_in;
   logic [COL_BITS:0]       rem_shift;
   logic                    rem_ge;

   // handshake and stage control
   logic busy, req_ready, accept, step, drain, emit, last_now, interior_now;
   logic s1_adv, s1_free, s2_free, s2_go, out_go;
   logic [WIDTH_BITS-1:0]  in_col_inc, ocol_inc;
   logic                   col_wrap, ocol_wrap;
   logic [PIXEL_BITS-1:0]  wr_pix;

   // stage 1: accepted beat plus line store read
   logic                   s1_valid_ff, s1_emit_ff, s1_interior_ff, s1_last_ff;
   logic [PIXEL_BITS-1:0]  s1_pix_ff;
   logic [SLOT_BITS-1:0]   s1_slot_ff;
   logic [PIXEL_BITS-1:0]  bank_rd [SLOTS];
   logic [PIXEL_BITS-1:0]  column [WIN];

   // window
   logic [PIXEL_BITS-1:0]  window_ff [WIN][WIN];

   // stage 2: centre, product and neighbours
   logic                   s2_valid_ff, s2_test_ff, s2_last_ff;
   logic [PIXEL_BITS-1:0]  s2_centre_ff;
   logic [PROD_BITS-1:0]   s2_mid_ff, mid_in;
   logic [PIXEL_BITS-1:0]  s2_nb_ff [4];

   // response register
   logic                   out_valid_ff, out_corr_ff, out_last_ff;
   logic [PIXEL_BITS-1:0]  out_pix_ff;
   logic [COUNT_BITS-1:0]  out_count_ff, total_ff, total_in;

   // compare and select
   logic [3:0]             below;
   logic [PIXEL_BITS-1:0]  masked [4];
   logic [PIXEL_BITS-1:0]  max01, max23, maxv, value;
   logic [HIT_BITS-1:0]    hits, need;
   logic                   fix;
   logic [PIXEL_BITS-1:0]  mid_hi;
   logic                   mid_lo_nz;

   logic [WIDTH_BITS-1:0]  w_raw, w_clamp;
   logic [HEIGHT_BITS-1:0] h_raw, h_clamp;

   // configuration writes
   always_comb begin
      w_raw = csr_bus.data[WIDTH_BITS-1:0];
      h_raw = csr_bus.data[HEIGHT_BITS-1:0];
      if (w_raw < WIDTH_BITS'(MIN_WIDTH)) begin
         w_clamp = WIDTH_BITS'(MIN_WIDTH);
      end else if (w_raw > WIDTH_BITS'(MAX_WIDTH)) begin
         w_clamp = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         w_clamp = w_raw;
      end
      if (h_raw < HEIGHT_BITS'(MIN_HEIGHT)) begin
         h_clamp = HEIGHT_BITS'(MIN_HEIGHT);
      end else if (h_raw > HEIGHT_BITS'(MAX_HEIGHT)) begin
         h_clamp = HEIGHT_BITS'(MAX_HEIGHT);
      end else begin
         h_clamp = h_raw;
      end
   end

   assign csr_bus.ready = 1'b1;
   assign area_wide = eff_w_ff * eff_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff  <= WIDTH_BITS'(4096);
         eff_h_ff  <= HEIGHT_BITS'(4096);
         thresh_ff <= PIXEL_BITS'(3277);
         gain_ff   <= GAIN_BITS'(8192);
         perm_ff   <= 1'b0;
         settle_ff <= 1'b0;
      end else begin
         settle_ff <= 1'b0;
         if (csr_bus.valid) begin
            case (csr_index_type'(csr_bus.index))
               CSR_IMAGE_WIDTH: begin
                  eff_w_ff  <= w_clamp;
                  settle_ff <= 1'b1;
               end
               CSR_IMAGE_HEIGHT: begin
                  eff_h_ff  <= h_clamp;
                  settle_ff <= 1'b1;
               end
               CSR_HOT_THRESHOLD:   thresh_ff <= csr_bus.data[PIXEL_BITS-1:0];
               CSR_NEIGHBOUR_GAIN:  gain_ff   <= csr_bus.data[GAIN_BITS-1:0];
               CSR_PERMISSIVE_MODE: perm_ff   <= csr_bus.data[0];
               default: ;
            endcase
         end
      end
   end

   // frame area follows the geometry in the next cycle
   always_ff @(posedge clock) begin
      area_ff <= area_wide[AREA_BITS-1:0];
   end

   // restoring divide, one quotient bit per cycle
   always_comb begin
      rem_shift = {rem_ff, quot_ff[INDEX_BITS-1]};
      rem_ge    = rem_shift >= eff_w_ff;
      rem_in    = rem_ge ? COL_BITS'(rem_shift - eff_w_ff) : rem_shift[COL_BITS-1:0];
      quot_in   = {quot_ff[INDEX_BITS-2:0], rem_ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (csr_bus.valid &&
                   csr_index_type'(csr_bus.index) == CSR_IMAGE_WIDTH) begin
         div_cnt_ff <= DIV_CNT_BITS'(DIV_STEPS);
      end else if (div_cnt_ff != '0) begin
         div_cnt_ff <= div_cnt_ff - DIV_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (csr_bus.valid && csr_index_type'(csr_bus.index) == CSR_IMAGE_WIDTH) begin
         quot_ff <= out_index_ff;
         rem_ff  <= '0;
      end else if (div_cnt_ff != '0) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   // stage flow: each stage moves on when the next one has room
   assign busy      = settle_ff || (div_cnt_ff != '0);
   assign out_go    = !out_valid_ff || rsp_bus.ready;
   assign s2_go     = s2_valid_ff && out_go;
   assign s2_free   = !s2_valid_ff || out_go;
   assign s1_adv    = s1_valid_ff && (!s1_emit_ff || s2_free);
   assign s1_free   = !s1_valid_ff || s1_adv;
   assign req_ready = s1_free && !busy;
   assign req_bus.ready = req_ready;
   assign accept    = req_bus.valid && req_ready;

   // beat classification against the current position
   always_comb begin
      drain  = in_row_ff >= ROW_BITS'(eff_h_ff);
      step   = accept && (drain || req_bus.opcode != OP_FLUSH);
      emit   = (in_row_ff > ROW_BITS'(BORDER)) ||
               (in_row_ff == ROW_BITS'(BORDER) && in_col_ff >= COL_BITS'(BORDER));
      wr_pix = drain ? '0 : req_bus.pixel_in;
      interior_now = (orow_ff >= ROW_BITS'(BORDER)) &&
                     (({1'b0, orow_ff} + (ROW_BITS+1)'(BORDER)) <
                      (ROW_BITS+1)'(eff_h_ff)) &&
                     (ocol_ff >= COL_BITS'(BORDER)) &&
                     (({1'b0, ocol_ff} + WIDTH_BITS'(BORDER)) < eff_w_ff);
      last_now = ({1'b0, out_index_ff} + AREA_BITS'(1)) >= area_ff;
   end

   // position counters step with each beat that is not an ignored flush
   always_comb begin
      in_col_inc   = {1'b0, in_col_ff} + WIDTH_BITS'(1);
      col_wrap     = in_col_inc >= eff_w_ff;
      ocol_inc     = {1'b0, ocol_ff} + WIDTH_BITS'(1);
      ocol_wrap    = ocol_inc >= eff_w_ff;
      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff;
      out_index_in = out_index_ff;
      orow_in      = orow_ff;
      ocol_in      = ocol_ff;
      if (step) begin
         if (emit && last_now) begin
            in_row_in    = '0;
            in_col_in    = '0;
            out_index_in = '0;
            orow_in      = '0;
            ocol_in      = '0;
         end else begin
            in_col_in = col_wrap ? '0 : in_col_inc[COL_BITS-1:0];
            in_row_in = in_row_ff + ROW_BITS'(col_wrap);
            if (emit) begin
               out_index_in = out_index_ff + INDEX_BITS'(1);
               ocol_in      = ocol_wrap ? '0 : ocol_inc[COL_BITS-1:0];
               orow_in      = orow_ff + ROW_BITS'(ocol_wrap);
            end
         end
      end else if (div_cnt_ff == DIV_CNT_BITS'(1)) begin
         orow_in = quot_in[ROW_BITS-1:0];
         ocol_in = rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         out_index_ff <= '0;
         orow_ff      <= '0;
         ocol_ff      <= '0;
      end else begin
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         out_index_ff <= out_index_in;
         orow_ff      <= orow_in;
         ocol_ff      <= ocol_in;
      end
   end

   // four row banks: write the row's own bank, read all four at the column
   for (genvar b = 0; b < SLOTS; b++) begin : g_bank
      bhpf_ram #(
         .WIDTH (PIXEL_BITS),
         .DEPTH (MAX_WIDTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (step && in_row_ff[SLOT_BITS-1:0] == SLOT_BITS'(b)),
         .wr_addr (in_col_ff),
         .wr_data (wr_pix),
         .rd_en   (step),
         .rd_addr (in_col_ff),
         .rd_data (bank_rd[b])
      );
   end

   // stage 1 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (step) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         s1_emit_ff     <= emit;
         s1_interior_ff <= interior_now;
         s1_last_ff     <= last_now;
         s1_pix_ff      <= wr_pix;
         s1_slot_ff     <= in_row_ff[SLOT_BITS-1:0];
      end
   end

   // incoming column, oldest row on top
   always_comb begin
      for (int r = 0; r < WIN - 1; r++) begin
         column[r] = bank_rd[SLOT_BITS'(int'(s1_slot_ff) + r)];
      end
      column[WIN-1] = s1_pix_ff;
   end

   // window shifts left by one column per beat
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         for (int r = 0; r < WIN; r++) begin
            for (int c = 0; c < WIN - 1; c++) begin
               window_ff[r][c] <= window_ff[r][c+1];
            end
            window_ff[r][WIN-1] <= column[r];
         end
      end
   end

   // stage 2: capture centre and neighbours of the shifted window
   assign mid_in = window_ff[WIN_MID][WIN_MID+1] * gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_adv && s1_emit_ff) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_go) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit_ff) begin
         s2_centre_ff <= window_ff[WIN_MID][WIN_MID+1];
         s2_mid_ff    <= mid_in;
         s2_test_ff   <= s1_interior_ff && (window_ff[WIN_MID][WIN_MID+1] > thresh_ff);
         s2_last_ff   <= s1_last_ff;
         s2_nb_ff[0]  <= window_ff[WIN_MID][1];
         s2_nb_ff[1]  <= window_ff[0][WIN_MID+1];
         s2_nb_ff[2]  <= column[WIN_MID];
         s2_nb_ff[3]  <= window_ff[WIN-1][WIN_MID+1];
      end
   end

   // neighbour test: centre * gain strictly above neighbour << 16
   always_comb begin
      mid_hi    = s2_mid_ff[PROD_BITS-1:GAIN_BITS];
      mid_lo_nz = |s2_mid_ff[GAIN_BITS-1:0];
      for (int k = 0; k < 4; k++) begin
         below[k]  = (mid_hi > s2_nb_ff[k]) || (mid_hi == s2_nb_ff[k] && mid_lo_nz);
         masked[k] = below[k] ? s2_nb_ff[k] : '0;
      end
      max01 = (masked[0] > masked[1]) ? masked[0] : masked[1];
      max23 = (masked[2] > masked[3]) ? masked[2] : masked[3];
      maxv  = (max01 > max23) ? max01 : max23;
      hits  = HIT_BITS'(below[0]) + HIT_BITS'(below[1]) +
              HIT_BITS'(below[2]) + HIT_BITS'(below[3]);
      need  = perm_ff ? HIT_BITS'(NEED_PERMISSIVE) : HIT_BITS'(NEED_ALL);
      fix   = s2_test_ff && (hits >= need);
      value = fix ? maxv : s2_centre_ff;
      total_in = (fix && total_ff != COUNT_MAX) ? total_ff + COUNT_BITS'(1) : total_ff;
   end

   // response register and per-frame count
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         if (s2_go) begin
            out_valid_ff <= 1'b1;
            total_ff     <= s2_last_ff ? '0 : total_in;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         out_pix_ff   <= value;
         out_corr_ff  <= fix;
         out_last_ff  <= s2_last_ff;
         out_count_ff <= total_in;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.pixel_out     = out_pix_ff;
   assign rsp_bus.corrected     = out_corr_ff;
   assign rsp_bus.last_of_frame = out_last_ff;
   assign rsp_bus.fixed_count   = out_count_ff;

endmodule

// ===== tb/tb_bayer_hot_pixel_fix.sv =====
`timescale 1ns / 100ps

import bhpf_pkg::*;

typedef struct packed {
   logic [PIXEL_BITS-1:0] pixel_out;
   logic                  corrected;
   logic                  last_of_frame;
   logic [COUNT_BITS-1:0] fixed_count;
} fixed_pixel_t;

// tracks the raster position, line store and window of the block and predicts every output beat
class hot_pixel_tracker;
   logic [WIDTH_BITS-1:0]          width_reg;
   logic [HEIGHT_BITS-1:0]         height_reg;
   logic [PIXEL_BITS-1:0]          threshold_reg;
   logic [GAIN_BITS-1:0]           gain_reg;
   logic                           permissive_reg;
   logic [PIXEL_BITS-1:0]          row_store [];
   logic [4:0][4:0][PIXEL_BITS-1:0] window;
   int unsigned                    in_row;
   int unsigned                    in_col;
   int unsigned                    out_index;
   logic [COUNT_BITS-1:0]          fixed_total;
   bit                             frame_closed;
   fixed_pixel_t                   pixels_due [$];
   int unsigned                    mismatches;

   function new();
      width_reg      = 4096;
      height_reg     = 4096;
      threshold_reg  = 3277;
      gain_reg       = 8192;
      permissive_reg = 1'b0;
      row_store      = new[SLOTS * MAX_WIDTH];
      foreach (row_store[i]) row_store[i] = '0;
      window         = '0;
      in_row         = 0;
      in_col         = 0;
      out_index      = 0;
      fixed_total    = '0;
      frame_closed   = 1'b0;
      mismatches     = 0;
   endfunction

   function int unsigned live_width();
      if (width_reg < MIN_WIDTH) return MIN_WIDTH;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
   endfunction

   function int unsigned live_height();
      if (height_reg < MIN_HEIGHT) return MIN_HEIGHT;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
   endfunction

   function bit draining();
      return in_row >= live_height();
   endfunction

   function void set_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_IMAGE_WIDTH:     width_reg      = data[WIDTH_BITS-1:0];
         CSR_IMAGE_HEIGHT:    height_reg     = data[HEIGHT_BITS-1:0];
         CSR_HOT_THRESHOLD:   threshold_reg  = data[PIXEL_BITS-1:0];
         CSR_NEIGHBOUR_GAIN:  gain_reg       = data[GAIN_BITS-1:0];
         CSR_PERMISSIVE_MODE: permissive_reg = data[0];
         default: ;
      endcase
   endfunction

   // accepted request beat: step the window and queue the pixel it releases, if any
   function void take_beat(op_type op, logic [PIXEL_BITS-1:0] pix_in);
      int unsigned            w, h, orow, ocol, slot, idx;
      longint unsigned        area, scaled, centre_wide;
      bit                     drain, emit, fixed, last;
      logic [PIXEL_BITS-1:0]  pix, centre, best;
      logic [3:0][PIXEL_BITS-1:0] nb;
      int                     r, c, k, hits, need;
      fixed_pixel_t           due;

      w = live_width();
      h = live_height();
      drain = in_row >= h;
      // flush while the frame is still coming in is dropped
      if (!drain && op == OP_FLUSH) return;
      pix = drain ? '0 : pix_in;
      emit = in_row > 2 || (in_row == 2 && in_col >= 2);

      // shift the window and pull the new column from the line store
      for (r = 0; r < 5; r++)
         for (c = 0; c < 4; c++)
            window[r][c] = window[r][c+1];
      for (k = 1; k <= 4; k++) begin
         slot = (in_row - k) & (SLOTS - 1);
         idx = slot * MAX_WIDTH + in_col;
         window[4-k][4] = (idx < SLOTS * MAX_WIDTH) ? row_store[idx] : '0;
      end
      window[4][4] = pix;
      idx = (in_row & (SLOTS - 1)) * MAX_WIDTH + in_col;
      if (idx < SLOTS * MAX_WIDTH) row_store[idx] = pix;

      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (!emit) return;

      centre = window[2][2];
      due.pixel_out = centre;
      fixed = 1'b0;
      orow = out_index / w;
      ocol = out_index % w;

      // interior pixel above threshold: count same-colour neighbours under centre times gain
      if (orow >= 2 && orow + 2 < h && ocol >= 2 && ocol + 2 < w && centre > threshold_reg) begin
         centre_wide = centre;
         scaled = centre_wide * gain_reg;
         nb[0] = window[2][0];
         nb[1] = window[0][2];
         nb[2] = window[2][4];
         nb[3] = window[4][2];
         hits = 0;
         best = '0;
         need = permissive_reg ? 3 : 4;
         for (k = 0; k < 4; k++) begin
            if (scaled > ({48'd0, nb[k]} << 16)) begin
               hits++;
               if (nb[k] > best) best = nb[k];
            end
         end
         if (hits >= need) begin
            due.pixel_out = best;
            fixed = 1'b1;
            if (fixed_total != COUNT_MAX) fixed_total++;
         end
      end

      area = w;
      area = area * h;
      last = out_index >= area - 1;
      due.corrected = fixed;
      due.last_of_frame = last;
      due.fixed_count = fixed_total;
      pixels_due.push_back(due);

      if (last) begin
         in_row = 0;
         in_col = 0;
         out_index = 0;
         fixed_total = '0;
         frame_closed = 1'b1;
      end else begin
         out_index++;
      end
   endfunction

   // accepted response beat against the oldest predicted pixel
   function void match_beat(logic [PIXEL_BITS-1:0] pixel_out, logic corrected,
                            logic last_of_frame, logic [COUNT_BITS-1:0] fixed_count);
      fixed_pixel_t due;

      if (pixels_due.size() == 0) begin
         $error("response beat with nothing pending: pixel_out %0d", pixel_out);
         mismatches++;
         return;
      end
      due = pixels_due.pop_front();
      if (pixel_out !== due.pixel_out) begin
         $error("pixel_out: expected %0d, actual %0d", due.pixel_out, pixel_out);
         mismatches++;
      end
      if (corrected !== due.corrected) begin
         $error("corrected: expected %0d, actual %0d", due.corrected, corrected);
         mismatches++;
      end
      if (last_of_frame !== due.last_of_frame) begin
         $error("last_of_frame: expected %0d, actual %0d", due.last_of_frame, last_of_frame);
         mismatches++;
      end
      if (fixed_count !== due.fixed_count) begin
         $error("fixed_count: expected %0d, actual %0d", due.fixed_count, fixed_count);
         mismatches++;
      end
   endfunction
endclass

module tb_bayer_hot_pixel_fix;

   // 6x5 frame: centre (2,2) hot with one neighbour on the exact gain boundary,
   // centre (2,3) with three low neighbours, extremes on the border
   localparam logic [PIXEL_BITS-1:0] TEST_IMAGE [30] = '{
      16'd0,  16'd65535, 16'd5,     16'd0,     16'd65535, 16'd7,
      16'd1,  16'd2,     16'd3,     16'd4,     16'd5,     16'd6,
      16'd9,  16'd8,     16'd40000, 16'd20001, 16'd100,   16'd65535,
      16'd11, 16'd12,    16'd13,    16'd14,    16'd15,    16'd16,
      16'd17, 16'd18,    16'd20000, 16'd10,    16'd65535, 16'd0
   };

   logic clock = 1'b0;
   logic reset;

   bhpf_req_if req_chan ();
   bhpf_rsp_if rsp_chan ();
   bhpf_csr_if csr_chan ();

   hot_pixel_tracker tracker;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_cycles_left;
   int base_max;

   bayer_hot_pixel_fix dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_chan),
      .rsp_bus (rsp_chan),
      .csr_bus (csr_chan)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // long receiver hold-off counts down here
   always @(posedge clock) begin
      if (hold_cycles_left > 0) hold_cycles_left <= hold_cycles_left - 1;
   end

   // receiver back-pressure
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= (hold_cycles_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         tracker.match_beat(rsp_chan.pixel_out, rsp_chan.corrected,
                            rsp_chan.last_of_frame, rsp_chan.fixed_count);
   end

   function automatic logic [PIXEL_BITS-1:0] pick_pixel();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return PIXEL_BITS'($urandom_range(0, base_max));
      if (roll < 75) return PIXEL_BITS'($urandom_range(32768, 65535));
      if (roll < 90) return PIXEL_BITS'($urandom());
      if (roll < 95) return '0;
      return '1;
   endfunction

   // one request beat, starting on a falling edge and returning at the accepting edge
   task automatic send_beat(op_type op, logic [PIXEL_BITS-1:0] pix);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.opcode   <= op;
      req_chan.pixel_in <= pix;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      tracker.take_beat(op, pix);
   endtask

   // stop offering and hold until every predicted pixel has come back
   task automatic wait_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (tracker.pixels_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      tracker.set_reg(idx, data);
      @(negedge clock);
   endtask

   // all registers, written once the block has gone quiet
   task automatic configure(logic [CSR_DATA_BITS-1:0] width, logic [CSR_DATA_BITS-1:0] height,
                            logic [CSR_DATA_BITS-1:0] threshold,
                            logic [CSR_DATA_BITS-1:0] gain, logic permissive);
      wait_results();
      repeat (8) @(negedge clock);
      write_reg(CSR_IMAGE_WIDTH, width);
      write_reg(CSR_IMAGE_HEIGHT, height);
      write_reg(CSR_HOT_THRESHOLD, threshold);
      write_reg(CSR_NEIGHBOUR_GAIN, gain);
      write_reg(CSR_PERMISSIVE_MODE, {15'd0, permissive});
      csr_chan.valid <= 1'b0;
   endtask

   task automatic random_setup();
      logic [CSR_DATA_BITS-1:0] width, height, threshold, gain;
      width  = ($urandom_range(9) == 0) ? $urandom_range(5) : $urandom_range(6, 14);
      height = ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(5, 10);
      case ($urandom_range(9))
         0:       threshold = '0;
         1:       threshold = '1;
         2, 3:    threshold = $urandom();
         default: threshold = $urandom_range(0, 8191);
      endcase
      case ($urandom_range(9))
         0:       gain = '0;
         1:       gain = 16'd32768;
         2:       gain = $urandom();
         default: gain = $urandom_range(4096, 32768);
      endcase
      case ($urandom_range(3))
         0:       base_max = 255;
         1:       base_max = 4095;
         2:       base_max = 16383;
         default: base_max = 65535;
      endcase
      configure(width, height, threshold, gain, $urandom_range(1));
   endtask

   task automatic stream_pixels(int count);
      int i;
      for (i = 0; i < count; i++) send_beat(OP_PIXEL, pick_pixel());
   endtask

   // feed until the frame closes: pixels, then drain flushes, with stray beats mixed in
   task automatic stream_frame(int hold_at, int pause_at, bit crafted);
      int     beats, pixels, drain_beats;
      op_type op;
      beats = 0;
      pixels = 0;
      drain_beats = 0;
      tracker.frame_closed = 1'b0;
      while (!tracker.frame_closed) begin
         if (beats == hold_at) hold_cycles_left = 400;
         if (beats == pause_at) wait_results();
         if (tracker.draining()) begin
            // a pixel beat here only acts as a flush
            if (crafted ? drain_beats == 0 : $urandom_range(9) == 0) op = OP_PIXEL;
            else op = OP_FLUSH;
            send_beat(op, PIXEL_BITS'($urandom()));
            drain_beats++;
         end else if (crafted ? beats == 0 : $urandom_range(19) == 0) begin
            // early flush, dropped by the block
            send_beat(OP_FLUSH, PIXEL_BITS'($urandom()));
         end else begin
            send_beat(OP_PIXEL, crafted ? TEST_IMAGE[pixels] : pick_pixel());
            pixels++;
         end
         beats++;
      end
   endtask

   initial begin
      int phase, f;

      tracker = new();
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.opcode = OP_PIXEL;
      req_chan.pixel_in = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_IMAGE_WIDTH;
      csr_chan.data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles_left = 0;
      base_max = 4095;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // crafted frame at the clamped minimum size: all four needed, then permissive
      // with the second centre sitting exactly on the threshold
      configure(0, 0, 1000, 32768, 1'b0);
      stream_frame(-1, -1, 1'b1);
      configure(0, 0, 20001, 32768, 1'b1);
      stream_frame(-1, -1, 1'b1);

      // over-range geometry clamps to the widest row; past one row, shrink mid-frame,
      // then change width again once pixels are coming out
      configure(16383, 32767, 4095, 16384, 1'b0);
      stream_pixels(MAX_WIDTH + 3);
      configure(8, 7, 4095, 16384, 1'b0);
      stream_pixels(30);
      configure(11, 7, 2000, 24576, 1'b1);
      stream_frame(-1, -1, 1'b0);

      // random frames through the idle patterns
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         for (f = 0; f < 3; f++) begin
            random_setup();
            stream_frame((phase == 0 && f == 1) ? 35 : -1, (phase == 3 && f == 1) ? 30 : -1,
                         1'b0);
         end
      end

      wait_results();
      repeat (20) @(negedge clock);
      if (tracker.mismatches == 0 && tracker.pixels_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== bayer_hot_pixel_fix.f =====
design/bhpf_pkg.sv
design/bhpf_req_if.sv
design/bhpf_rsp_if.sv
design/bhpf_csr_if.sv
design/bhpf_ram.sv
design/bayer_hot_pixel_fix.sv
tb/tb_bayer_hot_pixel_fix.sv
